// ----- hw/rtl/flr_pkg.sv -----
// Shared types and constants for the fixed-point line rasterizer.
// No dependencies; used by the front end, the queue, the back end, the top level and the testbench.
`timescale 1ns / 1ps

package flr_pkg;

  localparam int COLOR_W = 8;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  // Handshake between a producer and a consumer around the descriptor queue.
  typedef struct packed {
    logic push;
    logic pop;
  } q_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- hw/rtl/flr_front.sv -----
// Front end: takes a line command, picks the major axis and step direction,
// and divides the minor length by the major length one quotient bit a cycle.
// Depends on flr_pkg.
`timescale 1ns / 1ps

module flr_front import flr_pkg::*; #(
  parameter int COORD_BITS    = 6,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  color_t                color_in,
  output logic                  busy,
  input  q_stat_t               q_stat,
  output logic                  push,
  output logic                  y_major,
  output logic                  step_neg,
  output logic                  minor_neg,
  output logic [COORD_BITS-1:0] major_start,
  output logic [COORD_BITS-1:0] minor_start,
  output logic [COORD_BITS-1:0] line_len,
  output logic [FRACTION_BITS:0] slope_mag,
  output color_t                color
);

  localparam int NUM_W     = COORD_BITS + FRACTION_BITS;
  localparam int DIV_STEPS = COORD_BITS + FRACTION_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]            state;
  logic [CNT_W-1:0]      count;
  logic [NUM_W-1:0]      num;
  logic [COORD_BITS-1:0] rem;

  logic [COORD_BITS:0]   dx, dy, adx_w, ady_w;
  logic [COORD_BITS-1:0] adx, ady;
  logic                  ymaj_c;
  logic [COORD_BITS-1:0] len_c, minor_abs_c;
  logic [COORD_BITS:0]   trial;
  logic                  ge;
  logic                  accept;

  always_comb begin
    dx     = {1'b0, x_end} - {1'b0, x_start};
    dy     = {1'b0, y_end} - {1'b0, y_start};
    adx_w  = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    ady_w  = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
    adx    = adx_w[COORD_BITS-1:0];
    ady    = ady_w[COORD_BITS-1:0];
    // ties go to x
    ymaj_c      = ady > adx;
    len_c       = ymaj_c ? ady : adx;
    minor_abs_c = ymaj_c ? adx : ady;
  end

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign push   = (state == ST_PUSH) && !q_stat.full;

  // restoring division step
  assign trial = {rem, num[NUM_W-1]};
  assign ge    = trial >= {1'b0, line_len};

  assign slope_mag = num[FRACTION_BITS:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          // drop zero-length lines here: they yield no pixel
          if (accept && (len_c != '0)) begin
            state <= ST_DIV;
            count <= '0;
          end
        end
        ST_DIV: begin
          count <= count + 1'b1;
          if (count == CNT_W'(DIV_STEPS - 1)) state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!q_stat.full) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y_major     <= ymaj_c;
      step_neg    <= ymaj_c ? dy[COORD_BITS] : dx[COORD_BITS];
      minor_neg   <= ymaj_c ? dx[COORD_BITS] : dy[COORD_BITS];
      major_start <= ymaj_c ? y_start : x_start;
      minor_start <= ymaj_c ? x_start : y_start;
      line_len    <= len_c;
      color       <= color_in;
      num         <= {minor_abs_c, {FRACTION_BITS{1'b0}}};
      rem         <= '0;
    end else if (state == ST_DIV) begin
      num <= {num[NUM_W-2:0], ge};
      rem <= ge ? COORD_BITS'(trial - {1'b0, line_len}) : trial[COORD_BITS-1:0];
    end
  end

  // a finished division always moves on to the hand-off
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && count == CNT_W'(DIV_STEPS - 1)) |=> (state == ST_PUSH))
    else $error("divider did not finish into hand-off");

  // the minor length never exceeds the major, so the quotient fits FRACTION_BITS+1
  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    push |-> (num[NUM_W-1:FRACTION_BITS+1] == '0))
    else $error("slope quotient overflow");

endmodule

// ----- hw/rtl/flr_queue.sv -----
// Two-entry descriptor queue between the front end and the pixel stepper.
// Depends on flr_pkg.
`timescale 1ns / 1ps

module flr_queue import flr_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  q_req_t           req,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data,
  output q_stat_t          stat
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       fill;

  assign stat.full  = (fill == 2'd2);
  assign stat.empty = (fill == 2'd0);
  assign rd_data    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (req.push) wr_ptr <= ~wr_ptr;
      if (req.pop)  rd_ptr <= ~rd_ptr;
      case ({req.push, req.pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) entry[wr_ptr] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    req.push |-> !stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    req.pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule

// ----- hw/rtl/flr_back.sv -----
// Back end: steps the major axis one pixel a cycle and accumulates the slope
// for the minor axis. Pulls line descriptors from the queue. Depends on flr_pkg.
`timescale 1ns / 1ps

module flr_back import flr_pkg::*; #(
  parameter int COORD_BITS    = 6,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  q_stat_t                q_stat,
  output logic                   pop,
  input  logic                   d_y_major,
  input  logic                   d_step_neg,
  input  logic                   d_minor_neg,
  input  logic [COORD_BITS-1:0]  d_major_start,
  input  logic [COORD_BITS-1:0]  d_minor_start,
  input  logic [COORD_BITS-1:0]  d_line_len,
  input  logic [FRACTION_BITS:0] d_slope_mag,
  input  color_t                 d_color,
  output logic                   pixel_valid,
  output logic [COORD_BITS-1:0]  pixel_x,
  output logic [COORD_BITS-1:0]  pixel_y,
  output color_t                 pixel_color,
  output logic                   last_pixel
);

  localparam int ACC_W   = COORD_BITS + FRACTION_BITS + 1;
  localparam int SLOPE_W = FRACTION_BITS + 2;

  logic                       active;
  logic                       y_major, step_neg;
  logic [COORD_BITS-1:0]      major, minor_start, remaining;
  logic signed [SLOPE_W-1:0]  slope;
  logic signed [ACC_W-1:0]    acc;
  color_t                     color;

  logic                       is_last;
  logic [COORD_BITS-1:0]      minor_c;
  logic [SLOPE_W-1:0]         mag_ext;

  assign is_last = (remaining == COORD_BITS'(1));
  // low bits of the floor shift are just the accumulator's integer bits
  assign minor_c = minor_start + acc[FRACTION_BITS +: COORD_BITS];
  assign pop     = (!active || is_last) && !q_stat.empty;
  assign mag_ext = {1'b0, d_slope_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      pixel_valid <= active;
      if (pop)          active <= 1'b1;
      else if (is_last) active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      pixel_x     <= y_major ? minor_c : major;
      pixel_y     <= y_major ? major : minor_c;
      pixel_color <= color;
      last_pixel  <= is_last;
    end
    // load the next line over the final beat of the current one
    if (pop) begin
      y_major     <= d_y_major;
      step_neg    <= d_step_neg;
      major       <= d_major_start;
      minor_start <= d_minor_start;
      remaining   <= d_line_len;
      slope       <= d_minor_neg ? -$signed(mag_ext) : $signed(mag_ext);
      color       <= d_color;
      acc         <= '0;
    end else if (active) begin
      major       <= step_neg ? major - 1'b1 : major + 1'b1;
      acc         <= acc + ACC_W'(slope);
      remaining   <= remaining - 1'b1;
    end
  end

  a_last_has_beat: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && last_pixel) |-> $past(active && is_last))
    else $error("last flag without final step");

  a_no_zero_len: assert property (@(posedge clk) disable iff (rst)
    active |-> (remaining != '0))
    else $error("stepper active with nothing left");

endmodule

// ----- hw/rtl/fixed_point_line_rasterizer.sv -----
// Top level of the fixed-point DDA line rasterizer.
// Depends on flr_pkg, flr_front, flr_queue and flr_back.
//
//   channel   direction  handshake               payload
//   command   in         start / busy            x_start y_start x_end y_end red_in green_in blue_in
//   pixel     out        pixel_valid strobe      pixel_x pixel_y red_out green_out blue_out last_pixel
//
// A command is taken when start is high and busy low. The front end then works out
// COORD_BITS + FRACTION_BITS quotient bits (22 by default) in its bit-serial divider
// and enters a hand-off state that waits while the queue is full; the back end emits
// one pixel per cycle, and the next division overlaps the current line. Zero-length
// lines are dropped at acceptance and never raise busy. Reset (rst, synchronous)
// clears the control state. Pixels are strobed for one cycle and cannot be stalled.
`timescale 1ns / 1ps

module fixed_point_line_rasterizer import flr_pkg::*; #(
  parameter int COORD_BITS    = 6,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  logic [COLOR_W-1:0]    red_in,
  input  logic [COLOR_W-1:0]    green_in,
  input  logic [COLOR_W-1:0]    blue_in,
  output logic                  pixel_valid,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_W-1:0]    red_out,
  output logic [COLOR_W-1:0]    green_out,
  output logic [COLOR_W-1:0]    blue_out,
  output logic                  last_pixel
);

  localparam int DESC_W = 3 + 3 * COORD_BITS + FRACTION_BITS + 1 + $bits(color_t);

  color_t                 color_in, f_color, b_color, pix_color;
  q_req_t                 q_req;
  q_stat_t                q_stat;
  logic                   q_push, q_pop;
  logic                   f_y_major, f_step_neg, f_minor_neg;
  logic [COORD_BITS-1:0]  f_major_start, f_minor_start, f_len;
  logic [FRACTION_BITS:0] f_slope;
  logic                   b_y_major, b_step_neg, b_minor_neg;
  logic [COORD_BITS-1:0]  b_major_start, b_minor_start, b_len;
  logic [FRACTION_BITS:0] b_slope;
  logic [DESC_W-1:0]      wr_desc, rd_desc;

  assign color_in = '{red: red_in, green: green_in, blue: blue_in};
  assign q_req    = '{push: q_push, pop: q_pop};

  flr_front #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .color_in   (color_in),
    .busy       (busy),
    .q_stat     (q_stat),
    .push       (q_push),
    .y_major    (f_y_major),
    .step_neg   (f_step_neg),
    .minor_neg  (f_minor_neg),
    .major_start(f_major_start),
    .minor_start(f_minor_start),
    .line_len   (f_len),
    .slope_mag  (f_slope),
    .color      (f_color)
  );

  assign wr_desc = {f_y_major, f_step_neg, f_minor_neg, f_major_start, f_minor_start,
                    f_len, f_slope, f_color};

  flr_queue #(
    .WIDTH(DESC_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .req    (q_req),
    .wr_data(wr_desc),
    .rd_data(rd_desc),
    .stat   (q_stat)
  );

  assign {b_y_major, b_step_neg, b_minor_neg, b_major_start, b_minor_start,
          b_len, b_slope, b_color} = rd_desc;

  flr_back #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .pop          (q_pop),
    .d_y_major    (b_y_major),
    .d_step_neg   (b_step_neg),
    .d_minor_neg  (b_minor_neg),
    .d_major_start(b_major_start),
    .d_minor_start(b_minor_start),
    .d_line_len   (b_len),
    .d_slope_mag  (b_slope),
    .d_color      (b_color),
    .pixel_valid  (pixel_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pix_color),
    .last_pixel   (last_pixel)
  );

  assign red_out   = pix_color.red;
  assign green_out = pix_color.green;
  assign blue_out  = pix_color.blue;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the fixed-point line rasterizer: drives line commands and
// checks every strobed pixel against a DDA line predictor kept in the bench.
// Depends on flr_pkg and fixed_point_line_rasterizer.
`timescale 1ns / 1ps

module testbench;
  import flr_pkg::*;

  localparam int COORD_W = 6;
  localparam int FRAC_W = 16;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef logic [COORD_W-1:0] coord_t;

  localparam coord_t COORD_HI = coord_t'(COORD_MAX);

  typedef struct {
    coord_t x;
    coord_t y;
    color_t col;
    logic last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  coord_t x_start, y_start, x_end, y_end;
  logic [COLOR_W-1:0] red_in, green_in, blue_in;
  logic pixel_valid;
  coord_t pixel_x, pixel_y;
  logic [COLOR_W-1:0] red_out, green_out, blue_out;
  logic last_pixel;

  pixel_t expected_pixels[$];
  int error_count = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;

  fixed_point_line_rasterizer #(
    .COORD_BITS(COORD_W),
    .FRACTION_BITS(FRAC_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .x_start(x_start),
    .y_start(y_start),
    .x_end(x_end),
    .y_end(y_end),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .pixel_valid(pixel_valid),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .last_pixel(last_pixel)
  );

  always #2 clk = ~clk;

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Walk the major axis from the start, end point excluded, and queue each pixel.
  task automatic predict_line_pixels(input coord_t xs, input coord_t ys, input coord_t xe,
                                     input coord_t ye, input color_t col);
    longint xs_i, ys_i, major_d, minor_d, tmp, len, step, slope, acc, minor_c, px, py;
    bit y_major;
    pixel_t p;
    xs_i = longint'(xs);
    ys_i = longint'(ys);
    major_d = longint'(xe) - xs_i;
    minor_d = longint'(ye) - ys_i;
    y_major = 1'b0;
    // ties keep x as the major axis
    if (magnitude(minor_d) > magnitude(major_d)) begin
      tmp = minor_d;
      minor_d = major_d;
      major_d = tmp;
      y_major = 1'b1;
    end
    len = magnitude(major_d);
    if (len == 0) return;
    step = (major_d < 0) ? -1 : 1;
    // truncate toward zero: divide the magnitude, then apply the sign
    slope = (magnitude(minor_d) << FRAC_W) / len;
    if (minor_d < 0) slope = -slope;
    acc = 0;
    for (longint k = 0; k < len; k++) begin
      minor_c = acc >>> FRAC_W;
      if (y_major) begin
        px = xs_i + minor_c;
        py = ys_i + k * step;
      end else begin
        px = xs_i + k * step;
        py = ys_i + minor_c;
      end
      p.x = px[COORD_W-1:0];
      p.y = py[COORD_W-1:0];
      p.col = col;
      p.last = (k == len - 1);
      expected_pixels.push_back(p);
      acc += slope;
    end
  endtask

  // Drop start for a random number of cycles and scramble the idle command bus.
  task automatic sender_gap();
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do begin
        x_start <= coord_t'($urandom);
        y_start <= coord_t'($urandom);
        x_end <= coord_t'($urandom);
        y_end <= coord_t'($urandom);
        red_in <= COLOR_W'($urandom);
        green_in <= COLOR_W'($urandom);
        blue_in <= COLOR_W'($urandom);
        @(posedge clk);
      end while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Hold one command until busy lets it through, then record its pixels.
  task automatic send_line(input coord_t xs, input coord_t ys, input coord_t xe,
                           input coord_t ye, input color_t col);
    start <= 1'b1;
    x_start <= xs;
    y_start <= ys;
    x_end <= xe;
    y_end <= ye;
    red_in <= col.red;
    green_in <= col.green;
    blue_in <= col.blue;
    do @(posedge clk); while (busy !== 1'b0);
    predict_line_pixels(xs, ys, xe, ye, col);
    sender_gap();
  endtask

  function automatic color_t random_color();
    color_t c;
    c.red = COLOR_W'($urandom);
    c.green = COLOR_W'($urandom);
    c.blue = COLOR_W'($urandom);
    return c;
  endfunction

  task automatic test_zero_length();
    send_line('0, '0, '0, '0, '{8'hFF, 8'hFF, 8'hFF});
    send_line(COORD_HI, COORD_HI, COORD_HI, COORD_HI, '{8'h00, 8'h00, 8'h00});
    send_line(6'd17, 6'd42, 6'd17, 6'd42, random_color());
  endtask

  task automatic test_axis_lines();
    send_line('0, '0, COORD_HI, '0, '{8'hFF, 8'h00, 8'hAA});
    send_line(COORD_HI, '0, '0, '0, '{8'h00, 8'hFF, 8'h55});
    send_line('0, '0, '0, COORD_HI, '{8'hAA, 8'h55, 8'hFF});
    send_line('0, COORD_HI, '0, '0, '{8'h55, 8'hAA, 8'h00});
  endtask

  task automatic test_diagonal_ties();
    send_line('0, '0, COORD_HI, COORD_HI, random_color());
    send_line(COORD_HI, COORD_HI, '0, '0, random_color());
    send_line('0, COORD_HI, COORD_HI, '0, random_color());
    send_line(COORD_HI, '0, '0, COORD_HI, random_color());
    send_line(6'd5, 6'd5, 6'd4, 6'd4, random_color());
  endtask

  task automatic test_steep_and_shallow();
    send_line('0, '0, COORD_HI, 6'd1, random_color());
    send_line(COORD_HI, 6'd1, '0, '0, random_color());
    send_line('0, '0, 6'd1, COORD_HI, random_color());
    send_line(6'd1, '0, '0, COORD_HI, random_color());
    send_line(6'd10, 6'd20, 6'd30, 6'd13, random_color());
    send_line(6'd40, 6'd2, 6'd33, 6'd60, random_color());
    send_line(6'd5, 6'd5, 6'd6, 6'd5, random_color());
  endtask

  task automatic test_random_lines(input int count, input int idle_pct);
    coord_t xs, ys, xe, ye;
    int kind, room_x, room_y, d;
    bit neg_x, neg_y;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      xs = coord_t'($urandom);
      ys = coord_t'($urandom);
      xe = coord_t'($urandom);
      ye = coord_t'($urandom);
      kind = $urandom_range(99);
      if (kind < 8) begin
        xe = xs;
        ye = ys;
      end else if (kind < 16) begin
        ye = ys;
      end else if (kind < 24) begin
        xe = xs;
      end else if (kind < 34) begin
        neg_x = 1'($urandom_range(1));
        neg_y = 1'($urandom_range(1));
        room_x = neg_x ? int'(xs) : COORD_MAX - int'(xs);
        room_y = neg_y ? int'(ys) : COORD_MAX - int'(ys);
        d = (room_x < room_y) ? room_x : room_y;
        if (d > 0) begin
          d = $urandom_range(d, 1);
          xe = coord_t'(neg_x ? int'(xs) - d : int'(xs) + d);
          ye = coord_t'(neg_y ? int'(ys) - d : int'(ys) + d);
        end
      end else if (kind < 50) begin
        // short lines; at the edge a wrap turns one into a long line in the other direction
        xe = xs + coord_t'($urandom_range(6)) - coord_t'(3);
        ye = ys + coord_t'($urandom_range(6)) - coord_t'(3);
      end
      send_line(xs, ys, xe, ye, random_color());
    end
  endtask

  task automatic check_field(input string name, input longint exp, input longint act);
    if (exp != act) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, exp, act);
      error_count++;
    end
  endtask

  // Pixel checker and stall watchdog.
  always @(posedge clk) begin
    pixel_t p;
    if (rst !== 1'b0) begin
      quiet_cycles <= 0;
    end else begin
      if (pixel_valid === 1'b1) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t ns: pixel_valid expected 0 actual 1 (x=%0d y=%0d)", $time,
                   pixel_x, pixel_y);
          error_count++;
        end else begin
          p = expected_pixels.pop_front();
          check_field("pixel_x", longint'(p.x), longint'(pixel_x));
          check_field("pixel_y", longint'(p.y), longint'(pixel_y));
          check_field("red_out", longint'(p.col.red), longint'(red_out));
          check_field("green_out", longint'(p.col.green), longint'(green_out));
          check_field("blue_out", longint'(p.col.blue), longint'(blue_out));
          check_field("last_pixel", longint'(p.last), longint'(last_pixel));
        end
      end else if (pixel_valid !== 1'b0) begin
        $display("%0t ns: pixel_valid expected 0 actual %b", $time, pixel_valid);
        error_count++;
      end
      if (pixel_valid === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("fixed_point_line_rasterizer: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    x_start <= '0;
    y_start <= '0;
    x_end <= '0;
    y_end <= '0;
    red_in <= '0;
    green_in <= '0;
    blue_in <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 20;
    test_zero_length();
    test_axis_lines();
    test_diagonal_ties();
    test_steep_and_shallow();

    test_random_lines(160, 37);
    test_random_lines(150, 80);
    test_random_lines(160, 0);

    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("fixed_point_line_rasterizer: match");
    end else begin
      $display("fixed_point_line_rasterizer: mismatch");
    end
    $finish;
  end

endmodule
